// ----- rtl/core/upmix_pkg.sv -----
// Shared types and constants for the stereo to surround upmix block.
package upmix_pkg;

  // Work class that the front assigns to each word
  typedef enum logic [1:0] {
    OP_BYPASS,
    OP_UPMIX,
    OP_SURR_FRONT
  } op_e;

  localparam int OP_BITS = 2;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE          = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_MODE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_GAIN      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEADROOM_GAIN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERTER_DEGREE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERTER_GAIN   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT_THRESHOLD = 3'd6;

  // Output mode codes
  localparam logic [1:0] MODE_2_0_0 = 2'd0;
  localparam logic [1:0] MODE_0_2_0 = 2'd1;
  localparam logic [1:0] MODE_3_2_0 = 2'd2;

  // Fixed Q1.15 gains
  localparam logic signed [15:0] K_MINUS_2DB = 16'sd26029;
  localparam logic signed [15:0] K_MINUS_6DB = 16'sd16423;
  localparam int K_SHIFT = 15;

  // Reset values at their native widths (Q1.15 in 16 bits, Q1.23 in 24 bits)
  localparam longint RST_INPUT_GAIN    = 16423;
  localparam longint RST_HEADROOM_GAIN = 23198;
  localparam longint RST_INV_GAIN      = 32768;
  localparam longint RST_LIMIT         = 8380219;
  localparam int     RST_GAIN_WIDTH    = 16;
  localparam int     RST_SAMPLE_WIDTH  = 24;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

// ----- rtl/core/upmix_if.sv -----
// Valid/ready channel interfaces for stereo input words and five-channel output words.
interface upmix_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface upmix_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic signed [SAMPLE_BITS-1:0] center_out;
  logic signed [SAMPLE_BITS-1:0] left_surround_out;
  logic signed [SAMPLE_BITS-1:0] right_surround_out;

  modport source (output valid, output left_out, output right_out, output center_out,
                  output left_surround_out, output right_surround_out, input ready);
  modport sink   (input valid, input left_out, input right_out, input center_out,
                  input left_surround_out, input right_surround_out, output ready);
endinterface

// ----- rtl/core/upmix_queue.sv -----
// Small register queue that decouples the front from the processing back end.
module upmix_queue #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the configured depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue count did not follow push");

endmodule

// ----- rtl/core/upmix_front.sv -----
// Front end: accepts stereo words, classifies them by configuration and enqueues them.
module upmix_front #(
  parameter int SAMPLE_BITS = 24
) (
  upmix_in_if.sink                                        in_i,
  input  logic                                            enable_i,
  input  logic [1:0]                                      mode_i,
  input  logic                                            full_i,
  output logic                                            push_o,
  output logic [upmix_pkg::OP_BITS+2*SAMPLE_BITS-1:0]     entry_o
);
  import upmix_pkg::*;

  op_e op;

  always_comb begin
    if (!enable_i) begin
      op = OP_BYPASS;
    end else if (mode_i == MODE_0_2_0) begin
      op = OP_SURR_FRONT;
    end else begin
      op = OP_UPMIX;
    end
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign entry_o    = {op, in_i.left_in, in_i.right_in};

endmodule

// ----- rtl/core/upmix_back.sv -----
// Back end: five-stage arithmetic pipeline from queue entry to the output register.
module upmix_back #(
  parameter int SAMPLE_BITS = 24,
  parameter int GAIN_BITS   = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [GAIN_BITS-1:0]                        in_gain_i,
  input  logic [GAIN_BITS-1:0]                        hr_gain_i,
  input  logic [GAIN_BITS-1:0]                        inv_deg_i,
  input  logic [GAIN_BITS-1:0]                        inv_gain_i,
  input  logic [SAMPLE_BITS-2:0]                      thr_i,
  input  logic                                        empty_i,
  input  logic [upmix_pkg::OP_BITS+2*SAMPLE_BITS-1:0] entry_i,
  output logic                                        pop_o,
  upmix_out_if.source                                 out_o
);
  import upmix_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int GB = GAIN_BITS;
  localparam int EW = OP_BITS + 2 * SB;
  localparam int SW = SB + 1;  // scaled input
  localparam int VW = SB + 3;  // after inversion factor
  localparam int CW = SB + 1;  // centre before clamp
  localparam int FW = SB + 1;  // front before clamp
  localparam int LW = SB + 4;  // widest value fed to the limiter
  localparam int NST = 5;

  function automatic logic signed [SB-1:0] limit_fn(input logic signed [LW-1:0] x,
                                                    input logic [SB-2:0] t);
    logic signed [LW-1:0] tp;
    logic signed [LW-1:0] tn;
    tp = $signed({{(LW-SB+1){1'b0}}, t});
    tn = -tp;
    if (x > tp) begin
      return tp[SB-1:0];
    end else if (x < tn) begin
      return tn[SB-1:0];
    end
    return x[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] clamp_fn(input logic signed [SB:0] x);
    logic signed [SB:0] hi;
    logic signed [SB:0] lo;
    hi = $signed({2'b00, {(SB-1){1'b1}}});
    lo = -hi - (SB+1)'(1);
    if (x > hi) begin
      return hi[SB-1:0];
    end else if (x < lo) begin
      return lo[SB-1:0];
    end
    return x[SB-1:0];
  endfunction

  logic [NST-1:0] v_q;
  logic           adv;

  // Whole pipeline moves when the output register is free or being taken
  assign adv   = !v_q[NST-1] || out_o.ready;
  assign pop_o = adv && !empty_i;

  op_e                  op_in;
  logic signed [SB-1:0] l_in, r_in;
  assign op_in = op_e'(entry_i[EW-1 -: OP_BITS]);
  assign l_in  = $signed(entry_i[2*SB-1:SB]);
  assign r_in  = $signed(entry_i[SB-1:0]);

  // Stage 1: input gain
  logic signed [GB:0]      ig_s, hg_s, vg_s;
  logic signed [GB+1:0]    factor;
  logic signed [SB+GB:0]   pl, pr, shl, shr;
  logic signed [SW-1:0]    sl1_q, sr1_q;
  logic signed [SB-1:0]    l1_q, r1_q;
  op_e                     op1_q;

  assign ig_s   = $signed({1'b0, in_gain_i});
  assign hg_s   = $signed({1'b0, hr_gain_i});
  assign vg_s   = $signed({1'b0, inv_gain_i});
  assign factor = $signed((GB+2)'(1) << (GB-1)) - $signed({1'b0, inv_deg_i, 1'b0});
  assign pl     = l_in * ig_s;
  assign pr     = r_in * ig_s;
  assign shl    = pl >>> (GB-1);
  assign shr    = pr >>> (GB-1);

  // Stage 2: limited sum and inversion factor
  logic signed [LW-1:0]    sum2;
  logic signed [SB+GB+2:0] pvl, pvr, shvl, shvr;
  logic signed [SB-1:0]    lim2_q;
  logic signed [VW-1:0]    vl2_q, vr2_q;
  logic signed [SB-1:0]    l2_q, r2_q;
  op_e                     op2_q;

  assign sum2 = LW'(sl1_q) + LW'(sr1_q);
  assign pvl  = sl1_q * factor;
  assign pvr  = sr1_q * factor;
  assign shvl = pvl >>> (GB-1);
  assign shvr = pvr >>> (GB-1);

  // Stage 3: headroom gain and inverter gain with limit
  logic signed [SB+GB:0]   pc, shc;
  logic signed [SB+GB+3:0] pwl, pwr, shwl, shwr;
  logic signed [CW-1:0]    c3_q;
  logic signed [SB-1:0]    wl3_q, wr3_q;
  logic signed [SB-1:0]    l3_q, r3_q;
  op_e                     op3_q;

  assign pc   = lim2_q * hg_s;
  assign shc  = pc >>> (GB-1);
  assign pwl  = vl2_q * vg_s;
  assign pwr  = vr2_q * vg_s;
  assign shwl = pwl >>> (GB-1);
  assign shwr = pwr >>> (GB-1);

  // Stage 4: fixed -6 dB front and -2 dB surround trim
  logic signed [CW+15:0]   pf, shf;
  logic signed [SB+15:0]   pgl, pgr, shgl, shgr;
  logic signed [FW-1:0]    f4_q;
  logic signed [CW-1:0]    c4_q;
  logic signed [SB-1:0]    gl4_q, gr4_q;
  logic signed [SB-1:0]    l4_q, r4_q;
  op_e                     op4_q;

  assign pf   = c3_q * K_MINUS_6DB;
  assign shf  = pf >>> K_SHIFT;
  assign pgl  = wl3_q * K_MINUS_2DB;
  assign pgr  = wr3_q * K_MINUS_2DB;
  assign shgl = pgl >>> K_SHIFT;
  assign shgr = pgr >>> K_SHIFT;

  // Stage 5: surround sum, limit and channel routing into the output register
  logic signed [SB-1:0] ls5, rs5, lo_d, ro_d, co_d, lso_d, rso_d;
  logic signed [SB-1:0] lo_q, ro_q, co_q, lso_q, rso_q;
  op_e                  op5_q;

  assign ls5 = limit_fn(LW'(gl4_q) + LW'(f4_q), thr_i);
  assign rs5 = limit_fn(LW'(gr4_q) + LW'(f4_q), thr_i);

  always_comb begin
    lo_d  = clamp_fn(f4_q);
    ro_d  = clamp_fn(f4_q);
    co_d  = clamp_fn(c4_q);
    lso_d = ls5;
    rso_d = rs5;
    case (op4_q)
      OP_BYPASS: begin
        lo_d  = l4_q;
        ro_d  = r4_q;
        co_d  = '0;
        lso_d = '0;
        rso_d = '0;
      end
      OP_SURR_FRONT: begin
        lo_d = ls5;
        ro_d = rs5;
      end
      OP_UPMIX: begin
        lo_d = clamp_fn(f4_q);
        ro_d = clamp_fn(f4_q);
      end
      default: begin
        lo_d = clamp_fn(f4_q);
        ro_d = clamp_fn(f4_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sl1_q  <= shl[SW-1:0];
      sr1_q  <= shr[SW-1:0];
      l1_q   <= l_in;
      r1_q   <= r_in;
      op1_q  <= op_in;

      lim2_q <= limit_fn(sum2, thr_i);
      vl2_q  <= shvl[VW-1:0];
      vr2_q  <= shvr[VW-1:0];
      l2_q   <= l1_q;
      r2_q   <= r1_q;
      op2_q  <= op1_q;

      c3_q   <= shc[CW-1:0];
      wl3_q  <= limit_fn(shwl[LW-1:0], thr_i);
      wr3_q  <= limit_fn(shwr[LW-1:0], thr_i);
      l3_q   <= l2_q;
      r3_q   <= r2_q;
      op3_q  <= op2_q;

      f4_q   <= shf[FW-1:0];
      c4_q   <= c3_q;
      gl4_q  <= shgl[SB-1:0];
      gr4_q  <= shgr[SB-1:0];
      l4_q   <= l3_q;
      r4_q   <= r3_q;
      op4_q  <= op3_q;

      lo_q   <= lo_d;
      ro_q   <= ro_d;
      co_q   <= co_d;
      lso_q  <= lso_d;
      rso_q  <= rso_d;
      op5_q  <= op4_q;
    end
  end

  assign out_o.valid              = v_q[NST-1];
  assign out_o.left_out           = lo_q;
  assign out_o.right_out          = ro_q;
  assign out_o.center_out         = co_q;
  assign out_o.left_surround_out  = lso_q;
  assign out_o.right_surround_out = rso_q;

  a_bypass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-1] && op5_q == OP_BYPASS) |->
      (co_q == '0 && lso_q == '0 && rso_q == '0))
    else $error("bypass word carries nonzero centre or surround");

  a_surround_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-1] && op5_q != OP_BYPASS) |->
      ($signed(lso_q) <= $signed({1'b0, thr_i}) &&
       $signed(lso_q) >= -$signed({1'b0, thr_i})))
    else $error("left surround outside limiter threshold");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-1] && !out_o.ready) |=> $stable(v_q))
    else $error("pipeline moved while output stalled");

endmodule

// ----- rtl/core/stereo_to_surround_upmix.sv -----
// Path from input handshake to output valid: the front queue, then the back stages for
//   input gain, inversion factor, headroom and inverter gain, trims and output register.
// Throughput: one word per cycle unless the output stalls; only stages 1-4 multiply.
// A 4-entry queue absorbs input words while the output register is stalled.
// Reset: asynchronous active low; config returns to defaults, queue and pipeline empty.
// Configuration registers are written through the plain write port, no read-back.
module stereo_to_surround_upmix #(
  parameter int SAMPLE_BITS = 24,
  parameter int GAIN_BITS   = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  upmix_in_if.sink                                    frm_i,
  upmix_out_if.source                                 frm_o,
  input  logic                                        cfg_we_i,
  input  logic [upmix_pkg::CFG_IDX_BITS-1:0]          cfg_idx_i,
  input  logic [((GAIN_BITS > SAMPLE_BITS-1) ? GAIN_BITS : SAMPLE_BITS-1)-1:0] cfg_data_i
);
  import upmix_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int GB = GAIN_BITS;
  localparam int EW = OP_BITS + 2 * SB;

  localparam logic [GB-1:0] RST_IG = (GB >= RST_GAIN_WIDTH) ?
    GB'(RST_INPUT_GAIN << (GB - RST_GAIN_WIDTH)) :
    GB'(RST_INPUT_GAIN >> (RST_GAIN_WIDTH - GB));
  localparam logic [GB-1:0] RST_HG = (GB >= RST_GAIN_WIDTH) ?
    GB'(RST_HEADROOM_GAIN << (GB - RST_GAIN_WIDTH)) :
    GB'(RST_HEADROOM_GAIN >> (RST_GAIN_WIDTH - GB));
  localparam logic [GB-1:0] RST_VG = (GB >= RST_GAIN_WIDTH) ?
    GB'(RST_INV_GAIN << (GB - RST_GAIN_WIDTH)) :
    GB'(RST_INV_GAIN >> (RST_GAIN_WIDTH - GB));
  localparam logic [SB-2:0] RST_TH = (SB >= RST_SAMPLE_WIDTH) ?
    (SB-1)'(RST_LIMIT << (SB - RST_SAMPLE_WIDTH)) :
    (SB-1)'(RST_LIMIT >> (RST_SAMPLE_WIDTH - SB));

  logic          enable_q;
  logic [1:0]    mode_q;
  logic [GB-1:0] in_gain_q, hr_gain_q, inv_deg_q, inv_gain_q;
  logic [SB-2:0] thr_q;

  // Write registers by index; unknown indexes drop the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      mode_q     <= MODE_2_0_0;
      in_gain_q  <= RST_IG;
      hr_gain_q  <= RST_HG;
      inv_deg_q  <= '0;
      inv_gain_q <= RST_VG;
      thr_q      <= RST_TH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:          enable_q   <= cfg_data_i[0];
        REG_OUTPUT_MODE:     mode_q     <= cfg_data_i[1:0];
        REG_INPUT_GAIN:      in_gain_q  <= cfg_data_i[GB-1:0];
        REG_HEADROOM_GAIN:   hr_gain_q  <= cfg_data_i[GB-1:0];
        REG_INVERTER_DEGREE: inv_deg_q  <= cfg_data_i[GB-1:0];
        REG_INVERTER_GAIN:   inv_gain_q <= cfg_data_i[GB-1:0];
        REG_LIMIT_THRESHOLD: thr_q      <= cfg_data_i[SB-2:0];
        default: begin
        end
      endcase
    end
  end

  logic          push, pop, full, empty;
  logic [EW-1:0] wentry, rentry;

  upmix_front #(
    .SAMPLE_BITS(SB)
  ) u_front (
    .in_i     (frm_i),
    .enable_i (enable_q),
    .mode_i   (mode_q),
    .full_i   (full),
    .push_o   (push),
    .entry_o  (wentry)
  );

  upmix_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rentry),
    .empty_o (empty)
  );

  upmix_back #(
    .SAMPLE_BITS(SB),
    .GAIN_BITS(GB)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_gain_i  (in_gain_q),
    .hr_gain_i  (hr_gain_q),
    .inv_deg_i  (inv_deg_q),
    .inv_gain_i (inv_gain_q),
    .thr_i      (thr_q),
    .empty_i    (empty),
    .entry_i    (rentry),
    .pop_o      (pop),
    .out_o      (frm_o)
  );

endmodule

// ----- dv/stereo_to_surround_upmix_test.sv -----
// Self-checking testbench for the stereo to surround upmix block.
`timescale 1ns / 100ps

module stereo_to_surround_upmix_test;
  import upmix_pkg::*;

  localparam int  GAIN_FRAC      = 15;
  localparam int  DIRECTED_ROWS  = 22;
  localparam int  RAND_PHASES    = 10;
  localparam int  FRAMES_PER_SET = 80;
  localparam int  HOLD_CYCLES    = 64;
  localparam int  TAIL_CYCLES    = 12;
  localparam int  CYCLE_LIMIT    = 200000;

  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = 24'sh800000;

  // Index past the last register; writes to it must not land anywhere
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam logic [1:0]              MODE_SPARE = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_SEQUENCE [8] = '{
    REG_ENABLE, REG_OUTPUT_MODE, REG_INPUT_GAIN, REG_HEADROOM_GAIN,
    REG_INVERTER_DEGREE, REG_INVERTER_GAIN, REG_LIMIT_THRESHOLD, REG_UNUSED
  };

  // Directed register settings
  localparam logic [2:0] SET_RESET     = 3'd0;
  localparam logic [2:0] SET_BYPASS    = 3'd1;
  localparam logic [2:0] SET_CLIP_ZERO = 3'd2;
  localparam logic [2:0] SET_HOT       = 3'd3;
  localparam logic [2:0] SET_INVERT    = 3'd4;
  localparam logic [2:0] SET_SPARE     = 3'd5;

  typedef struct packed {
    logic        en;
    logic [1:0]  mode;
    logic [15:0] in_gain;
    logic [15:0] head_gain;
    logic [15:0] inv_degree;
    logic [15:0] inv_gain;
    logic [22:0] limit_thr;
  } upmix_cfg_t;

  typedef struct packed {
    logic signed [23:0] front_l;
    logic signed [23:0] front_r;
    logic signed [23:0] center;
    logic signed [23:0] surr_l;
    logic signed [23:0] surr_r;
  } surround_frame_t;

  typedef struct packed {
    logic [2:0]         setting;
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic               known;
    surround_frame_t    frame;
  } stim_row_t;

  localparam upmix_cfg_t RESET_CFG = '{
    1'b1, MODE_2_0_0, 16'(RST_INPUT_GAIN), 16'(RST_HEADROOM_GAIN), 16'd0,
    16'(RST_INV_GAIN), 23'(RST_LIMIT)
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [22:0]             cfg_data;

  upmix_in_if  #(.SAMPLE_BITS(24)) stereo_bus ();
  upmix_out_if #(.SAMPLE_BITS(24)) surround_bus ();

  stereo_to_surround_upmix #(
    .SAMPLE_BITS(24),
    .GAIN_BITS  (16)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frm_i     (stereo_bus),
    .frm_o     (surround_bus),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  upmix_cfg_t      active_cfg = RESET_CFG;
  surround_frame_t pending_frames [$];
  upmix_cfg_t      dir_cfg [6];
  stim_row_t       stim_table [DIRECTED_ROWS];

  int  mismatch_count  = 0;
  int  frames_checked  = 0;
  int  settings_loaded = 0;
  int  holds_issued    = 0;
  int  burst_left      = 0;
  int  cycle_count     = 0;
  bit  hold_start      = 1'b0;

  // ---------------- predictor ----------------

  function automatic longint clip_to(longint x, longint thr);
    if (x > thr) return thr;
    if (x < -thr) return -thr;
    return x;
  endfunction

  function automatic longint sat_sample(longint x);
    if (x > SAMPLE_MAX) return SAMPLE_MAX;
    if (x < SAMPLE_MIN) return SAMPLE_MIN;
    return x;
  endfunction

  function automatic longint surround_path(longint scaled, longint front, upmix_cfg_t c);
    longint factor, v, w, thr;
    thr    = longint'(c.limit_thr);
    factor = 64'sd32768 - 2 * longint'(c.inv_degree);
    v = (scaled * factor) >>> GAIN_FRAC;
    w = clip_to((v * longint'(c.inv_gain)) >>> GAIN_FRAC, thr);
    w = (w * longint'(K_MINUS_2DB)) >>> K_SHIFT;
    return clip_to(w + front, thr);
  endfunction

  function automatic surround_frame_t predict_upmix(upmix_cfg_t c, logic signed [23:0] l,
                                                    logic signed [23:0] r);
    longint sl, sr, cen, fnt, ls, rs;
    surround_frame_t o;
    o = '0;
    if (!c.en) begin
      o.front_l = l;
      o.front_r = r;
      return o;
    end
    sl  = (longint'(l) * longint'(c.in_gain)) >>> GAIN_FRAC;
    sr  = (longint'(r) * longint'(c.in_gain)) >>> GAIN_FRAC;
    cen = (clip_to(sl + sr, longint'(c.limit_thr)) * longint'(c.head_gain)) >>> GAIN_FRAC;
    fnt = (cen * longint'(K_MINUS_6DB)) >>> K_SHIFT;
    ls  = surround_path(sl, fnt, c);
    rs  = surround_path(sr, fnt, c);
    o.center = 24'(sat_sample(cen));
    o.surr_l = 24'(ls);
    o.surr_r = 24'(rs);
    if (c.mode == MODE_0_2_0) begin
      o.front_l = 24'(sat_sample(ls));
      o.front_r = 24'(sat_sample(rs));
    end else begin
      o.front_l = 24'(sat_sample(fnt));
      o.front_r = 24'(sat_sample(fnt));
    end
    return o;
  endfunction

  // ---------------- random draws ----------------

  function automatic logic [15:0] draw_gain();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic upmix_cfg_t draw_setting();
    upmix_cfg_t s;
    s.en         = ($urandom_range(0, 7) != 0);
    s.mode       = 2'($urandom_range(0, 3));
    s.in_gain    = draw_gain();
    s.head_gain  = draw_gain();
    s.inv_degree = draw_gain();
    s.inv_gain   = draw_gain();
    case ($urandom_range(0, 4))
      0: s.limit_thr = 23'd0;
      1: s.limit_thr = 23'h7FFFFF;
      2: s.limit_thr = 23'($urandom_range(0, 4096));
      default: s.limit_thr = 23'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic signed [23:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return ($urandom_range(0, 1) != 0) ? 24'sd0 : -24'sd1;
      3: return 24'($urandom_range(0, 8191)) - 24'sd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  // ---------------- stimulus ----------------

  task automatic load_setting(input upmix_cfg_t s);
    logic [22:0] value;
    for (int k = 0; k < 8; k++) begin
      case (REG_SEQUENCE[k])
        REG_ENABLE:          value = 23'(s.en);
        REG_OUTPUT_MODE:     value = 23'(s.mode);
        REG_INPUT_GAIN:      value = 23'(s.in_gain);
        REG_HEADROOM_GAIN:   value = 23'(s.head_gain);
        REG_INVERTER_DEGREE: value = 23'(s.inv_degree);
        REG_INVERTER_GAIN:   value = 23'(s.inv_gain);
        REG_LIMIT_THRESHOLD: value = s.limit_thr;
        default:             value = 23'($urandom);
      endcase
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_SEQUENCE[k];
      cfg_data <= value;
      @(posedge clk_i);
    end
    cfg_we     <= 1'b0;
    active_cfg  = s;
    settings_loaded++;
  endtask

  task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                            input logic known, input surround_frame_t known_frame);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        stereo_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    stereo_bus.valid    <= 1'b1;
    stereo_bus.left_in  <= l;
    stereo_bus.right_in <= r;
    do @(posedge clk_i); while (!stereo_bus.ready);
    pending_frames.push_back(known ? known_frame : predict_upmix(active_cfg, l, r));
    burst_left--;
  endtask

  // Hold off until every predicted word has come out
  task automatic drain_frames();
    stereo_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [2:0] current;
    rst_ni              = 1'b0;
    stereo_bus.valid    = 1'b0;
    stereo_bus.left_in  = '0;
    stereo_bus.right_in = '0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_ENABLE;
    cfg_data            = '0;

    dir_cfg[SET_RESET]     = RESET_CFG;
    dir_cfg[SET_BYPASS]    = RESET_CFG;
    dir_cfg[SET_BYPASS].en = 1'b0;
    dir_cfg[SET_CLIP_ZERO] = '{1'b1, MODE_3_2_0, 16'd16423, 16'd23198, 16'd0, 16'd32768,
                               23'd0};
    dir_cfg[SET_HOT]       = '{1'b1, MODE_0_2_0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               23'h7FFFFF};
    dir_cfg[SET_INVERT]    = '{1'b1, MODE_3_2_0, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
                               23'd8380219};
    dir_cfg[SET_SPARE]     = '{1'b1, MODE_SPARE, 16'd40000, 16'd0, 16'd12000, 16'd0,
                               23'd4000000};

    stim_table = '{
      '{SET_RESET,     24'sd0,       24'sd0,        1'b1, '0},
      '{SET_RESET,     S_MAX,        S_MAX,         1'b0, '0},
      '{SET_RESET,     S_MIN,        S_MIN,         1'b0, '0},
      '{SET_RESET,     S_MAX,        S_MIN,         1'b0, '0},
      '{SET_RESET,     S_MIN,        S_MAX,         1'b0, '0},
      '{SET_RESET,     24'sd1,       -24'sd1,       1'b0, '0},
      '{SET_BYPASS,    S_MAX,        S_MIN,         1'b1, '{S_MAX, S_MIN, 24'sd0, 24'sd0, 24'sd0}},
      '{SET_BYPASS,    S_MIN,        24'sd12345,    1'b1,
        '{S_MIN, 24'sd12345, 24'sd0, 24'sd0, 24'sd0}},
      '{SET_BYPASS,    24'sd0,       -24'sd1,       1'b1,
        '{24'sd0, -24'sd1, 24'sd0, 24'sd0, 24'sd0}},
      '{SET_CLIP_ZERO, S_MAX,        S_MAX,         1'b1, '0},
      '{SET_CLIP_ZERO, S_MIN,        S_MAX,         1'b1, '0},
      '{SET_HOT,       S_MAX,        S_MAX,         1'b0, '0},
      '{SET_HOT,       S_MIN,        S_MIN,         1'b0, '0},
      '{SET_HOT,       S_MAX,        -24'sd1,       1'b0, '0},
      '{SET_HOT,       S_MIN,        24'sd0,        1'b0, '0},
      '{SET_INVERT,    S_MAX,        S_MAX,         1'b0, '0},
      '{SET_INVERT,    S_MIN,        S_MIN,         1'b0, '0},
      '{SET_INVERT,    24'sd4194304, -24'sd4194304, 1'b0, '0},
      '{SET_INVERT,    -24'sd1,      -24'sd1,       1'b0, '0},
      '{SET_SPARE,     S_MAX,        24'sd0,        1'b0, '0},
      '{SET_SPARE,     S_MIN,        S_MIN,         1'b0, '0},
      '{SET_SPARE,     24'sd123456,  -24'sd654321,  1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part starts on the reset values, then walks the fixed settings
    current = SET_RESET;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (stim_table[i].setting != current) begin
        drain_frames();
        load_setting(dir_cfg[stim_table[i].setting]);
        current = stim_table[i].setting;
      end
      send_frame(stim_table[i].left, stim_table[i].right, stim_table[i].known,
                 stim_table[i].frame);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_frames();
      load_setting(draw_setting());
      if (ph == 1 || ph == 6) begin
        hold_start = 1'b1;
        holds_issued++;
      end
      for (int n = 0; n < FRAMES_PER_SET; n++)
        send_frame(draw_sample(), draw_sample(), 1'b0, '0);
    end

    drain_frames();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d output words across %0d register settings (all registers, extremes",
             frames_checked, settings_loaded);
    $display("  and the spare mode included), with %0d long output holds.", holds_issued);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("stereo_to_surround_upmix regression: pass");
    end else begin
      $display("stereo_to_surround_upmix regression: fail");
    end
    $finish;
  end

  // ---------------- output side ----------------

  initial begin : sink_pacing
    int phase_left;
    int stall_pct;
    int hold_left;
    phase_left = 0;
    stall_pct  = 0;
    hold_left  = 0;
    surround_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      phase_left--;
      if (hold_left != 0) begin
        hold_left--;
        surround_bus.ready <= 1'b0;
      end else begin
        surround_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic check_sample(input string name, input logic signed [23:0] want,
                              input logic signed [23:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    surround_frame_t want;
    if (rst_ni && surround_bus.valid && surround_bus.ready) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected output word, expected none, actual %0d %0d %0d %0d %0d",
                 $time, surround_bus.left_out, surround_bus.right_out,
                 surround_bus.center_out, surround_bus.left_surround_out,
                 surround_bus.right_surround_out);
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        check_sample("left_out", want.front_l, surround_bus.left_out);
        check_sample("right_out", want.front_r, surround_bus.right_out);
        check_sample("center_out", want.center, surround_bus.center_out);
        check_sample("left_surround_out", want.surr_l, surround_bus.left_surround_out);
        check_sample("right_surround_out", want.surr_r, surround_bus.right_surround_out);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d words outstanding.", cycle_count,
             pending_frames.size());
    $display("stereo_to_surround_upmix regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/upmix_pkg.sv
rtl/core/upmix_if.sv
rtl/core/upmix_queue.sv
rtl/core/upmix_front.sv
rtl/core/upmix_back.sv
rtl/core/stereo_to_surround_upmix.sv
dv/stereo_to_surround_upmix_test.sv
